>>> hdl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types, codes and defaults for the periodic query scheduler.
// ----------------------------------------------------------------------------
package psq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int TIME_W   = 32;
    localparam int ID_W     = 16;
    localparam int PERIOD_W = 16;

    // Result status codes.
    localparam logic [1:0] ST_REGISTERED = 2'd0;
    localparam logic [1:0] ST_EMITTED    = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    // Input mode codes.
    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_EMIT     = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]   fire_time;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
    } entry_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REPLACE
    } op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        op_t    op;
        entry_t entry;
    } cmd_t;

    // Firing time after one period, clamped at the largest time.
    function automatic logic [TIME_W-1:0] next_time(
        input logic [TIME_W-1:0]   t,
        input logic [PERIOD_W-1:0] p
    );
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, t} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, p};
            next_time = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        end
    endfunction

endpackage

>>> hdl/psq_cell.sv
// ----------------------------------------------------------------------------
// psq_cell
// One slot of the sorted queue. Cells are kept in ascending order of
// (firing time, id, registration slot); cell 0 holds the earliest entry.
// ----------------------------------------------------------------------------
module psq_cell #(
    parameter int SLOT_W = 6,
    parameter int CNT_W  = 7,
    parameter int INDEX  = 0
) (
    input  logic                clk,
    input  psq_pkg::cmd_t       cmd,
    input  logic [SLOT_W-1:0]   cmd_slot,
    input  logic [CNT_W-1:0]    count,
    input  logic                left_gt,
    input  psq_pkg::entry_t     left_entry,
    input  logic [SLOT_W-1:0]   left_slot,
    input  logic                right_lt,
    input  psq_pkg::entry_t     right_entry,
    input  logic [SLOT_W-1:0]   right_slot,
    output logic                gt,
    output logic                lt,
    output psq_pkg::entry_t     entry,
    output logic [SLOT_W-1:0]   slot
);

    psq_pkg::entry_t     entry_reg;
    psq_pkg::entry_t     entry_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                occupied;
    logic                key_gt;
    logic                key_lt;

    assign occupied = CNT_W'(INDEX) < count;

    // Slots are unique, so the full key never ties between two entries.
    assign key_gt = {entry_reg.fire_time, entry_reg.id, slot_reg}
                  > {cmd.entry.fire_time, cmd.entry.id, cmd_slot};
    assign key_lt = {entry_reg.fire_time, entry_reg.id, slot_reg}
                  < {cmd.entry.fire_time, cmd.entry.id, cmd_slot};

    assign gt = !occupied || key_gt;
    assign lt = occupied && key_lt;

    always_comb
    begin
        entry_next = entry_reg;
        slot_next  = slot_reg;
        case (cmd.op)
            psq_pkg::OP_INSERT:
            begin
                // Every cell past the insertion point moves one place right.
                if (gt)
                begin
                    if (left_gt)
                    begin
                        entry_next = left_entry;
                        slot_next  = left_slot;
                    end
                    else
                    begin
                        entry_next = cmd.entry;
                        slot_next  = cmd_slot;
                    end
                end
            end
            psq_pkg::OP_REPLACE:
            begin
                // The head leaves; earlier entries move left until the
                // updated head entry finds its place.
                if (right_lt)
                begin
                    entry_next = right_entry;
                    slot_next  = right_slot;
                end
                else if (lt || INDEX == 0)
                begin
                    entry_next = cmd.entry;
                    slot_next  = cmd_slot;
                end
            end
            default:
            begin
                entry_next = entry_reg;
                slot_next  = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        slot_reg  <= slot_next;
    end

    assign entry = entry_reg;
    assign slot  = slot_reg;

endmodule

>>> hdl/periodic_query_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic_query_scheduler_unit
// Periodic query scheduler built as a sorted chain of queue cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall, fields mode, query_id, period): mode 0
// registers a query whose first firing time equals its period; mode 1 emits
// the query with the earliest firing time (ties to the smaller id, then to
// the earlier registration) and pushes its time on by one period, clamped
// at the largest time value.
// Output channel (out_valid / out_stall): exactly one result per input
// transfer, carrying status, fired_id and fire_time.
// Each item goes through the accept cycle, which forms the broadcast key
// (the saturating add on the head entry), and the apply state, in which
// every cell compares and shifts one place in parallel and the result is
// written to the output register. The input stalls until the apply state
// has passed, so the block works on one item at a time.
// A stalled result holds the output register and blocks the next transfer
// until it is taken. Reset empties the queue at once; cell contents are
// never read before being written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_query_scheduler_unit #(
    parameter int CAPACITY = psq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [psq_pkg::ID_W-1:0]      query_id,
    input  logic [psq_pkg::PERIOD_W-1:0]  period,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [psq_pkg::ID_W-1:0]      fired_id,
    output logic [psq_pkg::TIME_W-1:0]    fire_time
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               count_reg;
    psq_pkg::cmd_t                  cmd_reg;
    logic [SLOT_W-1:0]              cmd_slot_reg;
    logic [1:0]                     pend_status_reg;
    logic [psq_pkg::ID_W-1:0]       pend_id_reg;
    logic [psq_pkg::TIME_W-1:0]     pend_time_reg;
    logic                           out_valid_reg;
    logic [1:0]                     status_reg;
    logic [psq_pkg::ID_W-1:0]       fired_id_reg;
    logic [psq_pkg::TIME_W-1:0]     fire_time_reg;

    logic                           accept;
    psq_pkg::cmd_t                  cmd_next;
    logic [SLOT_W-1:0]              cmd_slot_next;
    logic [1:0]                     pend_status_next;
    logic [psq_pkg::ID_W-1:0]       pend_id_next;
    logic [psq_pkg::TIME_W-1:0]     pend_time_next;

    psq_pkg::entry_t                cell_entry [CAPACITY];
    logic [SLOT_W-1:0]              cell_slot  [CAPACITY];
    logic                           cell_gt    [CAPACITY];
    logic                           cell_lt    [CAPACITY];

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // Key for the chain, formed in the accept cycle from the input or the head.
    always_comb
    begin
        cmd_next         = '{op: psq_pkg::OP_NONE, entry: '0};
        cmd_slot_next    = '0;
        pend_status_next = psq_pkg::ST_REGISTERED;
        pend_id_next     = '0;
        pend_time_next   = '0;
        if (mode == psq_pkg::MODE_REGISTER)
        begin
            if (count_reg == CNT_W'(CAPACITY))
            begin
                pend_status_next = psq_pkg::ST_FULL;
            end
            else
            begin
                cmd_next.op              = psq_pkg::OP_INSERT;
                cmd_next.entry.fire_time = {{(psq_pkg::TIME_W - psq_pkg::PERIOD_W){1'b0}},
                                            period};
                cmd_next.entry.id        = query_id;
                cmd_next.entry.period    = period;
                cmd_slot_next            = count_reg[SLOT_W-1:0];
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                pend_status_next = psq_pkg::ST_EMPTY;
            end
            else
            begin
                pend_status_next         = psq_pkg::ST_EMITTED;
                pend_id_next             = cell_entry[0].id;
                pend_time_next           = cell_entry[0].fire_time;
                cmd_next.op              = psq_pkg::OP_REPLACE;
                cmd_next.entry.fire_time = psq_pkg::next_time(cell_entry[0].fire_time,
                                                              cell_entry[0].period);
                cmd_next.entry.id        = cell_entry[0].id;
                cmd_next.entry.period    = cell_entry[0].period;
                cmd_slot_next            = cell_slot[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmd_reg.op    <= psq_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg         <= cmd_next;
                        cmd_slot_reg    <= cmd_slot_next;
                        pend_status_reg <= pend_status_next;
                        pend_id_reg     <= pend_id_next;
                        pend_time_reg   <= pend_time_next;
                        state_reg       <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    // The chain shifts at this edge; the result goes out.
                    if (cmd_reg.op == psq_pkg::OP_INSERT)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    cmd_reg.op    <= psq_pkg::OP_NONE;
                    out_valid_reg <= 1'b1;
                    status_reg    <= pend_status_reg;
                    fired_id_reg  <= pend_id_reg;
                    fire_time_reg <= pend_time_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                left_gt;
            psq_pkg::entry_t     left_entry;
            logic [SLOT_W-1:0]   left_slot;
            logic                right_lt;
            psq_pkg::entry_t     right_entry;
            logic [SLOT_W-1:0]   right_slot;

            if (i == 0)
            begin : g_head
                assign left_gt    = 1'b0;
                assign left_entry = '0;
                assign left_slot  = '0;
            end
            else
            begin : g_body
                assign left_gt    = cell_gt[i-1];
                assign left_entry = cell_entry[i-1];
                assign left_slot  = cell_slot[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_lt    = 1'b0;
                assign right_entry = '0;
                assign right_slot  = '0;
            end
            else
            begin : g_inner
                assign right_lt    = cell_lt[i+1];
                assign right_entry = cell_entry[i+1];
                assign right_slot  = cell_slot[i+1];
            end

            psq_cell #(
                .SLOT_W (SLOT_W),
                .CNT_W  (CNT_W),
                .INDEX  (i)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd_reg),
                .cmd_slot    (cmd_slot_reg),
                .count       (count_reg),
                .left_gt     (left_gt),
                .left_entry  (left_entry),
                .left_slot   (left_slot),
                .right_lt    (right_lt),
                .right_entry (right_entry),
                .right_slot  (right_slot),
                .gt          (cell_gt[i]),
                .lt          (cell_lt[i]),
                .entry       (cell_entry[i]),
                .slot        (cell_slot[i])
            );
        end
    endgenerate

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign fired_id  = fired_id_reg;
    assign fire_time = fire_time_reg;

endmodule

>>> hdl/psq_checker.sv
// ----------------------------------------------------------------------------
// psq_checker
// Port-level checks for the periodic query scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module psq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [psq_pkg::ID_W-1:0]      fired_id,
    input logic [psq_pkg::TIME_W-1:0]    fire_time
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(fired_id) && $stable(fire_time))
        else $error("stalled result changed");

    // Only an emitted result carries an id and a time.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != psq_pkg::ST_EMITTED |-> fired_id == '0 && fire_time == '0)
        else $error("non-emit result carries id or time");

    // The block works on one item at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while busy");

    // Each input transfer is followed by its result on the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("result missing after input transfer");

endmodule

bind periodic_query_scheduler_unit psq_checker u_psq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .fired_id  (fired_id),
    .fire_time (fire_time)
);

>>> verif/periodic_query_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// periodic_query_scheduler_unit_test
// Self-checking bench for the periodic query scheduler. Registers and emits
// go through the valid/stall input channel while a local table of entries
// predicts each result. Every result transfer is compared with the oldest
// prediction. The tests cover the empty table, the tie rules, a long random
// mix, zero periods and the full table.
// ----------------------------------------------------------------------------
module periodic_query_scheduler_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = psq_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT  = 50_000;
    localparam int RANDOM_ITEMS = 620;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0]                 status;
        logic [psq_pkg::ID_W-1:0]   fired_id;
        logic [psq_pkg::TIME_W-1:0] fire_time;
    } firing_t;

    typedef struct {
        logic [psq_pkg::ID_W-1:0]     id;
        logic [psq_pkg::PERIOD_W-1:0] period;
        logic [psq_pkg::TIME_W-1:0]   due;
    } slot_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic                         mode      = psq_pkg::MODE_REGISTER;
    logic [psq_pkg::ID_W-1:0]     query_id  = '0;
    logic [psq_pkg::PERIOD_W-1:0] period    = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [1:0]                   status;
    logic [psq_pkg::ID_W-1:0]     fired_id;
    logic [psq_pkg::TIME_W-1:0]   fire_time;

    slot_t   sched_table [CAPACITY];
    int      table_count = 0;
    firing_t pending_firings [$];
    firing_t due_firing;
    int      error_count = 0;
    int      cycle_count = 0;
    int      stall_left  = 0;
    bit      idle_on     = 1'b1;

    periodic_query_scheduler_unit #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .query_id  (query_id),
        .period    (period),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .fired_id  (fired_id),
        .fire_time (fire_time)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one item to the local table and returns the result it causes.
    function automatic firing_t next_firing(
        input logic                         m,
        input logic [psq_pkg::ID_W-1:0]     qid,
        input logic [psq_pkg::PERIOD_W-1:0] per
    );
        firing_t                  r;
        int                       best;
        int                       i;
        logic [psq_pkg::TIME_W:0] sum;
        r = '0;
        if (m == psq_pkg::MODE_REGISTER)
        begin
            if (table_count >= CAPACITY)
            begin
                r.status = psq_pkg::ST_FULL;
            end
            else
            begin
                sched_table[table_count] = '{qid, per,
                    {{(psq_pkg::TIME_W - psq_pkg::PERIOD_W){1'b0}}, per}};
                table_count++;
                r.status = psq_pkg::ST_REGISTERED;
            end
        end
        else if (table_count == 0)
        begin
            r.status = psq_pkg::ST_EMPTY;
        end
        else
        begin
            // Earliest time wins, then the smaller id, then the lower slot.
            best = 0;
            for (i = 1; i < table_count; i++)
            begin
                if (sched_table[i].due < sched_table[best].due ||
                    (sched_table[i].due == sched_table[best].due &&
                     sched_table[i].id < sched_table[best].id))
                begin
                    best = i;
                end
            end
            r.status    = psq_pkg::ST_EMITTED;
            r.fired_id  = sched_table[best].id;
            r.fire_time = sched_table[best].due;
            sum = {1'b0, sched_table[best].due} +
                  {{(psq_pkg::TIME_W + 1 - psq_pkg::PERIOD_W){1'b0}},
                   sched_table[best].period};
            sched_table[best].due = sum[psq_pkg::TIME_W] ? {psq_pkg::TIME_W{1'b1}}
                                                         : sum[psq_pkg::TIME_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [psq_pkg::ID_W-1:0] pick_id();
        // Half of the ids come from a narrow range so that duplicates occur.
        if ($urandom_range(0, 1) == 0)
        begin
            return psq_pkg::ID_W'($urandom_range(0, 7));
        end
        return psq_pkg::ID_W'($urandom);
    endfunction

    function automatic logic [psq_pkg::PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 3))
            0:       return psq_pkg::PERIOD_W'($urandom_range(1, 8));
            1:       return psq_pkg::PERIOD_W'($urandom_range(1, 1000));
            default: return psq_pkg::PERIOD_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Sends one item and records its expected result once the transfer happens.
    task automatic send_item(
        input logic                         m,
        input logic [psq_pkg::ID_W-1:0]     qid,
        input logic [psq_pkg::PERIOD_W-1:0] per
    );
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        query_id <= qid;
        period   <= per;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_firings.push_back(next_firing(m, qid, per));
    endtask

    task automatic emit_next();
        send_item(psq_pkg::MODE_EMIT, psq_pkg::ID_W'($urandom),
                  psq_pkg::PERIOD_W'($urandom));
    endtask

    task automatic test_empty_table();
        emit_next();
        send_item(psq_pkg::MODE_EMIT, '0, '0);
        send_item(psq_pkg::MODE_EMIT, '1, '1);
    endtask

    task automatic test_firing_order();
        int n;
        send_item(psq_pkg::MODE_REGISTER, 16'd0, 16'd1);
        send_item(psq_pkg::MODE_REGISTER, 16'd100, 16'd3);
        send_item(psq_pkg::MODE_REGISTER, 16'd50, 16'd3);
        send_item(psq_pkg::MODE_REGISTER, 16'd50, 16'd3);
        send_item(psq_pkg::MODE_REGISTER, 16'd7, 16'hFFFF);
        for (n = 0; n < 12; n++)
        begin
            emit_next();
        end
    endtask

    // A few slots are kept free for the zero period entries at the end.
    task automatic test_random_mix();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (table_count < CAPACITY - 4 && $urandom_range(0, 3) == 0)
            begin
                send_item(psq_pkg::MODE_REGISTER, pick_id(), pick_period());
            end
            else
            begin
                emit_next();
            end
        end
    endtask

    task automatic test_zero_period_and_full();
        int n;
        send_item(psq_pkg::MODE_REGISTER, 16'd9, 16'd0);
        send_item(psq_pkg::MODE_REGISTER, 16'd9, 16'd0);
        for (n = 0; n < 3; n++)
        begin
            emit_next();
        end
        while (table_count < CAPACITY)
        begin
            send_item(psq_pkg::MODE_REGISTER, pick_id(), pick_period());
        end
        send_item(psq_pkg::MODE_REGISTER, '1, '0);
        send_item(psq_pkg::MODE_REGISTER, '0, '1);
        send_item(psq_pkg::MODE_REGISTER, pick_id(), pick_period());
        for (n = 0; n < 4; n++)
        begin
            emit_next();
        end
    endtask

    // Receiver stalls come in random bursts while idle_on is set.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_firings.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                begin
                    $display("unexpected result: status %0d id %0d time %0d",
                             status, fired_id, fire_time);
                end
                error_count++;
            end
            else
            begin
                due_firing = pending_firings.pop_front();
                if (status !== due_firing.status || fired_id !== due_firing.fired_id ||
                    fire_time !== due_firing.fire_time)
                begin
                    if (error_count < MAX_REPORTS)
                    begin
                        $display({"mismatch: expected status %0d id %0d time %0d,",
                                  " got %0d %0d %0d"},
                                 due_firing.status, due_firing.fired_id, due_firing.fire_time,
                                 status, fired_id, fire_time);
                    end
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("periodic_query_scheduler_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_firing_order();
        test_random_mix();
        idle_on <= 1'b0;
        test_zero_period_and_full();
        in_valid <= 1'b0;
        while (pending_firings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_firings.size() == 0)
        begin
            $display("periodic_query_scheduler_unit_test: clean");
        end
        else
        begin
            $display("periodic_query_scheduler_unit_test: errors");
        end
        $finish;
    end

endmodule
